// ===== design/triggered_shaped_decay_envelope_unit_macros.svh =====
// Assertion macros for the envelope unit
`ifndef TRIGGERED_SHAPED_DECAY_ENVELOPE_UNIT_MACROS_SVH
`define TRIGGERED_SHAPED_DECAY_ENVELOPE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TSDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSDE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSDE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/tsde_pkg.sv =====
// Shared types, widths and constants of the envelope unit
package tsde_pkg;

    localparam int P_SAMPLE_WIDTH   = 16;
    localparam int P_TIME_FRAC_BITS = 24;

    localparam int SP_W    = 15;
    localparam int DT_W    = 26;
    localparam int SHAPE_W = 16;
    localparam int ROOT_W  = 17;
    localparam int AMT_W   = 17;
    localparam int CFG_W   = 26;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [IDX_W-1:0] REG_DECAY_TIME    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHAPE         = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHAPE_ROOT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CV_AMOUNT     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CV_ENABLE     = 3'd5;

    localparam logic [SP_W-1:0]    RST_SAMPLE_PERIOD = 15'd350;
    localparam logic [DT_W-1:0]    RST_DECAY_TIME    = 26'd16777216;
    localparam logic [SHAPE_W-1:0] RST_SHAPE         = 16'd32768;
    localparam logic [ROOT_W-1:0]  RST_SHAPE_ROOT    = 17'd53222;
    localparam logic [AMT_W-1:0]   RST_CV_AMOUNT     = 17'd32768;

    localparam int QW        = 35;
    localparam int DVW       = 35;
    localparam int QFRAC     = 30;
    localparam int DIV_STEPS = 30;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam int E_W       = 17;
    localparam int ENV_W     = 16;
    localparam int OUT_TW    = 24;
    localparam logic [E_W-1:0] E_ONE = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRONT,
        S_CLASS,
        S_DIVU,
        S_MUL_UU,
        S_MUL_TR,
        S_MUL_K,
        S_MUL_KU,
        S_FIN,
        S_DIVR,
        S_TAKEQ,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_UU,
        MUL_TR,
        MUL_K,
        MUL_KU
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    front;
        logic    classify;
        logic    div_step;
        mul_op_t mul_op;
        logic    fin;
        logic    take_q;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic curve;
        logic div_needed;
        logic out_free;
    } status_t;

endpackage

// ===== design/tsde_ctrl.sv =====
// Sequencer of the envelope unit: steps the datapath through one sample
`include "triggered_shaped_decay_envelope_unit_macros.svh"
module tsde_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tsde_pkg::status_t st,
    output tsde_pkg::cmd_t    cmd
);
    import tsde_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                cmd.front  = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                cnt_next     = '0;
                state_next   = st.curve ? S_DIVU : S_OUT;
            end
            S_DIVU:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL_UU;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL_UU:
            begin
                cmd.mul_op = MUL_UU;
                state_next = S_MUL_TR;
            end
            S_MUL_TR:
            begin
                cmd.mul_op = MUL_TR;
                state_next = S_MUL_K;
            end
            S_MUL_K:
            begin
                cmd.mul_op = MUL_K;
                state_next = S_MUL_KU;
            end
            S_MUL_KU:
            begin
                cmd.mul_op = MUL_KU;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                cnt_next   = '0;
                state_next = st.div_needed ? S_DIVR : S_OUT;
            end
            S_DIVR:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_TAKEQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TAKEQ:
            begin
                cmd.take_q = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TSDE_ASSERT_ALWAYS(a_cnt_range, clk, cnt_reg <= DIV_LAST, "divider step count out of range")
    `TSDE_ASSERT(a_load_free, clk, rst_n, cmd.out_load |-> st.out_free, "output word overwritten")
    `TSDE_ASSERT(a_accept_front, clk, rst_n, (s_tvalid && s_tready) |=> state_reg == S_FRONT,
                 "accepted word not processed")

endmodule

// ===== design/tsde_datapath.sv =====
// Datapath of the envelope unit: state, shared multiplier, serial divider, output word
`include "triggered_shaped_decay_envelope_unit_macros.svh"
module tsde_datapath
#(
    parameter int SAMPLE_WIDTH   = tsde_pkg::P_SAMPLE_WIDTH,
    parameter int TIME_FRAC_BITS = tsde_pkg::P_TIME_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsde_pkg::cmd_t             cmd,
    output tsde_pkg::status_t          st,
    input  logic [SAMPLE_WIDTH-1:0]    trig_in,
    input  logic [SAMPLE_WIDTH-1:0]    cv_in,
    input  logic                       wr_en,
    input  logic [tsde_pkg::IDX_W-1:0] wr_index,
    input  logic [tsde_pkg::CFG_W-1:0] wr_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [tsde_pkg::OUT_TW-1:0] m_tdata
);
    import tsde_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int TFB  = TIME_FRAC_BITS;
    localparam int ETW  = TFB + 2;
    localparam int LW   = TFB - 4;
    localparam int LCW  = (LW > SP_W) ? LW : SP_W;
    localparam int DSW  = SW + TFB + 20;
    localparam int SH   = TFB - SW - 14;
    localparam int SHL  = (SH > 0) ? SH : 0;
    localparam int SHR  = (SH < 0) ? -SH : 0;
    localparam int AWW  = ETW + 27;

    localparam logic [63:0] TIME_ONE     = 64'd1 << TFB;
    localparam logic [63:0] ATTACK_TICKS = (TIME_ONE + 64'd999) / 64'd1000;
    localparam logic [63:0] LIGHT_TICKS  = (TIME_ONE * 64'd3) / 64'd100;
    localparam logic [ETW-1:0] ATTACK_T  = ETW'(ATTACK_TICKS);
    localparam logic [LW-1:0]  LIGHT_T   = LW'(LIGHT_TICKS);
    localparam logic signed [DSW-1:0] DMIN_S = DSW'(TIME_ONE / 64'd100);
    localparam logic signed [DSW-1:0] DMAX_S = DSW'(TIME_ONE * 64'd2);
    localparam logic signed [SW+7:0]  FULL_S = (SW+8)'(1) << (SW - 1);
    localparam logic signed [QW-1:0]  ONE_Q   = QW'(64'd1 << QFRAC);
    localparam logic signed [QW-1:0]  THREE_Q = QW'(64'd3 << QFRAC);
    localparam logic signed [QW-1:0]  FRONT_OFFSET = QW'(64'd966367642);

    // configuration
    logic [SP_W-1:0]    sp_reg;
    logic [DT_W-1:0]    dt_reg;
    logic [SHAPE_W-1:0] shape_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [AMT_W-1:0]   amt_reg;
    logic               cv_en_reg;

    // sample state
    logic           trig_high_reg, trig_high_next;
    logic           gate_on_reg, gate_on_next;
    logic [ETW-1:0] elapsed_reg, elapsed_next;
    logic [LW-1:0]  light_reg, light_next;
    logic           light_flag_reg, light_flag_next;
    logic           out_valid_reg;

    // payload
    logic [SW-1:0]    trig_reg, cv_reg;
    logic [ETW-1:0]   decay_reg, decay_next;
    logic signed [QW-1:0] kf_reg, kb_reg, t_reg, k_reg, ku_reg;
    logic [DVW-1:0]   div_rem_reg, div_b_reg;
    logic [DIV_STEPS-1:0] div_q_reg;
    logic [E_W-1:0]   e_reg;
    logic [ENV_W-1:0] env_out_reg;
    logic             light_out_reg, active_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= RST_SAMPLE_PERIOD;
            dt_reg    <= RST_DECAY_TIME;
            shape_reg <= RST_SHAPE;
            root_reg  <= RST_SHAPE_ROOT;
            amt_reg   <= RST_CV_AMOUNT;
            cv_en_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SAMPLE_PERIOD: sp_reg    <= wr_data[SP_W-1:0];
                REG_DECAY_TIME:    dt_reg    <= wr_data[DT_W-1:0];
                REG_SHAPE:         shape_reg <= wr_data[SHAPE_W-1:0];
                REG_SHAPE_ROOT:    root_reg  <= wr_data[ROOT_W-1:0];
                REG_CV_AMOUNT:     amt_reg   <= wr_data[AMT_W-1:0];
                REG_CV_ENABLE:     cv_en_reg <= wr_data[0];
                default:           ;
            endcase
        end
    end

    // curve constants: kb = floor((root*2^17 + 2) / 5) - 1, split as 26214*root + (2*root+2)/5
    logic [ROOT_W+1:0] kb_y;
    logic [ROOT_W+21:0] kb_yq;
    logic signed [QW-1:0] kb_calc, kf_calc;

    always_comb
    begin
        kb_y    = {1'b0, root_reg, 1'b0} + (ROOT_W+2)'(2);
        kb_yq   = ((ROOT_W+22)'(kb_y) * (ROOT_W+22)'(838861)) >> 22;
        kb_calc = $signed(QW'(root_reg) * QW'(26214)) + $signed(QW'(kb_yq)) - ONE_Q;
        kf_calc = $signed(QW'({shape_reg, 13'b0})) - FRONT_OFFSET;
    end

    // trigger, light and decay time
    logic signed [SW+7:0]  trig_w, trig100, trig5;
    logic                  fire;
    logic [LW-1:0]         light_now;
    logic [LCW-1:0]        light_cw, sp_cw;
    logic signed [SW+17:0] cvp;
    logic signed [DSW-1:0] term, dsum;

    always_comb
    begin
        trig_w  = $signed({{8{trig_reg[SW-1]}}, trig_reg});
        trig100 = trig_w * $signed((SW+8)'(100));
        trig5   = trig_w * $signed((SW+8)'(5));
        fire    = !trig_high_reg && (trig5 >= FULL_S);
        trig_high_next = trig_high_reg;
        if (trig_high_reg && (trig100 <= FULL_S))
            trig_high_next = 1'b0;
        else if (fire)
            trig_high_next = 1'b1;

        light_now = (fire && (light_reg < LIGHT_T)) ? LIGHT_T : light_reg;
        light_flag_next = (light_now != '0);
        light_cw = LCW'(light_now);
        sp_cw    = LCW'(sp_reg);
        light_next = (light_cw > sp_cw) ? LW'(light_cw - sp_cw) : '0;

        cvp  = $signed(cv_reg) * $signed({1'b0, amt_reg});
        term = (DSW'(cvp) <<< SHL) >>> SHR;
        dsum = $signed(DSW'(dt_reg)) + (cv_en_reg ? term : '0);
        if (dsum < DMIN_S)
            decay_next = ETW'(DMIN_S);
        else if (dsum > DMAX_S)
            decay_next = ETW'(DMAX_S);
        else
            decay_next = ETW'(dsum);
    end

    // attack / decay decision
    logic           attack, decay_done, curve_w;
    logic [ETW-1:0] dp;
    logic [AWW-1:0] atk_w;
    logic [E_W-1:0] atk_e;
    logic [ETW:0]   el_sum;

    always_comb
    begin
        attack     = elapsed_reg < ATTACK_T;
        dp         = elapsed_reg - ATTACK_T;
        decay_done = dp >= decay_reg;
        atk_w      = AWW'(elapsed_reg) * AWW'(1000);
        atk_e      = E_W'((atk_w << 16) >> TFB);
        el_sum     = {1'b0, elapsed_reg} + (ETW+1)'(sp_reg);
        elapsed_next = el_sum[ETW] ? '1 : el_sum[ETW-1:0];
        gate_on_next = gate_on_reg && (attack || !decay_done);
        curve_w      = gate_on_reg && !attack && !decay_done;
    end

    // shared multiplier, Q30 products floored
    logic signed [QW-1:0]   u_s, ma, mb, mq;
    logic signed [2*QW-1:0] prod;

    always_comb
    begin
        u_s = $signed(QW'(div_q_reg));
        case (cmd.mul_op)
            MUL_UU:
            begin
                ma = u_s;
                mb = u_s;
            end
            MUL_TR:
            begin
                ma = t_reg;
                mb = THREE_Q - (u_s <<< 1);
            end
            MUL_K:
            begin
                ma = kb_reg - kf_reg;
                mb = t_reg;
            end
            MUL_KU:
            begin
                ma = k_reg;
                mb = u_s;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod = ma * mb;
        mq   = QW'(prod >>> QFRAC);
    end

    // curve quotient set-up
    logic signed [QW-1:0] num, den, anum, aden, r_dz;
    logic                 den_zero, num_zero, neg, big, div_needed_w;
    logic [QFRAC:0]       r_q;

    always_comb
    begin
        num      = u_s - ku_reg;
        den      = ONE_Q + k_reg - (ku_reg <<< 1);
        den_zero = (den == '0);
        num_zero = (num == '0);
        neg      = num[QW-1] ^ den[QW-1];
        anum     = num[QW-1] ? -num : num;
        aden     = den[QW-1] ? -den : den;
        big      = $unsigned(anum) >= $unsigned(aden);
        r_dz     = ONE_Q - u_s;
        r_q      = (QFRAC+1)'(ONE_Q) - {1'b0, div_q_reg};
        div_needed_w = !den_zero && !num_zero && !neg && !big;
    end

    // one restoring divide step
    logic [DVW:0] rem2;
    logic         ge;

    always_comb
    begin
        rem2 = {div_rem_reg, 1'b0};
        ge   = rem2 >= {1'b0, div_b_reg};
    end

    logic [33:0] env_w;
    logic        out_free_w;

    always_comb
    begin
        env_w = {1'b0, e_reg, 16'b0} - 34'(e_reg) + 34'd32768;
        out_free_w = !out_valid_reg || m_tready;
    end

    assign st = {curve_w, div_needed_w, out_free_w};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_high_reg  <= 1'b0;
            gate_on_reg    <= 1'b0;
            elapsed_reg    <= '0;
            light_reg      <= '0;
            light_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.front)
            begin
                trig_high_reg  <= trig_high_next;
                light_reg      <= light_next;
                light_flag_reg <= light_flag_next;
                if (fire)
                begin
                    elapsed_reg <= '0;
                    gate_on_reg <= 1'b1;
                end
            end
            if (cmd.classify && gate_on_reg)
            begin
                elapsed_reg <= elapsed_next;
                gate_on_reg <= gate_on_next;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        kb_reg <= kb_calc;
        kf_reg <= kf_calc;
        if (cmd.load)
        begin
            trig_reg <= trig_in;
            cv_reg   <= cv_in;
        end
        if (cmd.front)
            decay_reg <= decay_next;
        if (cmd.classify)
        begin
            e_reg <= (gate_on_reg && attack) ? atk_e : '0;
            if (st.curve)
            begin
                div_rem_reg <= DVW'(dp);
                div_b_reg   <= DVW'(decay_reg);
            end
        end
        if (cmd.div_step)
        begin
            div_rem_reg <= ge ? DVW'(rem2 - {1'b0, div_b_reg}) : rem2[DVW-1:0];
            div_q_reg   <= {div_q_reg[DIV_STEPS-2:0], ge};
        end
        case (cmd.mul_op)
            MUL_UU, MUL_TR: t_reg  <= mq;
            MUL_K:          k_reg  <= kf_reg + mq;
            MUL_KU:         ku_reg <= mq;
            default:        ;
        endcase
        if (cmd.fin)
        begin
            if (den_zero)
                e_reg <= r_dz[QFRAC:14];
            else if (num_zero || neg)
                e_reg <= E_ONE;
            else if (big)
                e_reg <= '0;
            else
            begin
                div_rem_reg <= $unsigned(anum);
                div_b_reg   <= $unsigned(aden);
            end
        end
        if (cmd.take_q)
            e_reg <= r_q[QFRAC:14];
        if (cmd.out_load)
        begin
            env_out_reg    <= env_w[31:16];
            light_out_reg  <= light_flag_reg;
            active_out_reg <= gate_on_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TW-ENV_W-2)'(0), active_out_reg, light_out_reg, env_out_reg};

    `TSDE_ASSERT(a_light_max, clk, rst_n, light_reg <= LIGHT_T, "light time above pulse length")
    `TSDE_ASSERT(a_gate_close, clk, rst_n, $fell(gate_on_reg) |-> $past(cmd.classify),
                 "gate closed outside decision step")
    `TSDE_ASSERT(a_level_max, clk, rst_n, cmd.out_load |-> e_reg <= E_ONE, "level above one")

endmodule

// ===== design/triggered_shaped_decay_envelope_unit.sv =====
// Sequence: idle, gate-off, attack and finished-decay samples go from the front and decision
// states straight to the output; other decay samples run a 30-step serial divide (one bit per
// cycle) and four shared-multiplier steps, and a second 30-step divide when the curve quotient
// is divided out. A new word is accepted only after the last has reached the output register,
// which holds the sequencer while full; a finished result waits there while the next is accepted.
// Reset: rst_n clears the envelope state and sets all configuration registers to their defaults at once.
module triggered_shaped_decay_envelope_unit
#(
    parameter int SAMPLE_WIDTH   = tsde_pkg::P_SAMPLE_WIDTH,
    parameter int TIME_FRAC_BITS = tsde_pkg::P_TIME_FRAC_BITS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // trigger_sample, decay_cv
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // env_level, trig_light, env_active
    output logic [tsde_pkg::OUT_TW-1:0]          m_tdata,
    input  logic                                 wr_en,
    input  logic [tsde_pkg::IDX_W-1:0]           wr_index,
    input  logic [tsde_pkg::CFG_W-1:0]           wr_data
);
    import tsde_pkg::*;

    cmd_t    cmd;
    status_t st;

    tsde_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tsde_datapath
    #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .trig_in  (s_tdata[SAMPLE_WIDTH-1:0]),
        .cv_in    (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/tsde_checker.sv =====
// Checker for the envelope unit: predicts each result word and compares it with the DUT output
module tsde_checker
    import tsde_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TW-1:0]      m_tdata,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_index,
    input  logic [CFG_W-1:0]       wr_data,
    output int                     fail_count,
    output int                     pending,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_ONE        = 64'sd1 << 30;
    localparam longint ATTACK_TICKS = 16778;
    localparam longint LIGHT_TICKS  = 503316;
    localparam longint DECAY_MIN    = 167772;
    localparam longint DECAY_MAX    = 33554432;
    localparam longint ELAPSED_MAX  = (64'sd1 << 26) - 1;
    localparam longint FRONT_OFFSET = 966367642;
    localparam longint FULL_SCALE   = 32768;

    typedef struct {
        logic [ENV_W-1:0] env_level;
        logic             trig_light;
        logic             env_active;
    } env_word_t;

    logic [SP_W-1:0]    cfg_period;
    logic [DT_W-1:0]    cfg_decay;
    logic [SHAPE_W-1:0] cfg_shape;
    logic [ROOT_W-1:0]  cfg_root;
    logic [AMT_W-1:0]   cfg_amount;
    logic               cfg_cv_en;

    logic   trig_high;
    logic   gate;
    longint elapsed;
    longint light_left;

    env_word_t level_q[$];

    function automatic longint mulq(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint curve_level(longint phase, longint total);
        longint u, kf, kb, tr, k, den, num, r;
        u   = (phase <<< 30) / total;
        kf  = (longint'(cfg_shape) <<< 13) - FRONT_OFFSET;
        kb  = ((longint'(cfg_root) <<< 17) + 2) / 5 - Q_ONE;
        tr  = mulq(mulq(u, u), 3 * Q_ONE - 2 * u);
        k   = kf + mulq(kb - kf, tr);
        den = Q_ONE + k - 2 * mulq(k, u);
        if (den == 0)
        begin
            r = Q_ONE - u;
        end
        else
        begin
            num = u - mulq(k, u);
            r = Q_ONE - (num * Q_ONE) / den;
        end
        if (r < 0)
            r = 0;
        if (r > Q_ONE)
            r = Q_ONE;
        return r >>> 14;
    endfunction

    function automatic env_word_t envelope_step(logic signed [15:0] trig_s,
                                                logic signed [15:0] cv_s);
        longint    t, c, per, dec, dp, e;
        logic      fire;
        env_word_t w;
        t    = trig_s;
        c    = cv_s;
        per  = longint'(cfg_period);
        fire = 1'b0;
        e    = 0;
        if (trig_high)
        begin
            if (t * 100 <= FULL_SCALE)
                trig_high = 1'b0;
        end
        else if (t * 5 >= FULL_SCALE)
        begin
            trig_high = 1'b1;
            fire = 1'b1;
        end
        if (fire)
        begin
            elapsed = 0;
            gate = 1'b1;
            if (light_left < LIGHT_TICKS)
                light_left = LIGHT_TICKS;
        end
        w.trig_light = (light_left > 0);
        if (w.trig_light)
            light_left = (light_left > per) ? light_left - per : 0;
        dec = longint'(cfg_decay);
        if (cfg_cv_en)
            dec += (c * longint'(cfg_amount)) >>> 6;
        if (dec < DECAY_MIN)
            dec = DECAY_MIN;
        if (dec > DECAY_MAX)
            dec = DECAY_MAX;
        if (gate)
        begin
            if (elapsed < ATTACK_TICKS)
            begin
                e = (elapsed * 1000 * 65536) >>> 24;
            end
            else
            begin
                dp = elapsed - ATTACK_TICKS;
                if (dp >= dec)
                    gate = 1'b0;
                else
                    e = curve_level(dp, dec);
            end
            elapsed += per;
            if (elapsed > ELAPSED_MAX)
                elapsed = ELAPSED_MAX;
        end
        w.env_level  = ENV_W'((e * 65535 + 32768) >>> 16);
        w.env_active = gate;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        env_word_t exp_w;
        if (!rst_n)
        begin
            cfg_period = RST_SAMPLE_PERIOD;
            cfg_decay  = RST_DECAY_TIME;
            cfg_shape  = RST_SHAPE;
            cfg_root   = RST_SHAPE_ROOT;
            cfg_amount = RST_CV_AMOUNT;
            cfg_cv_en  = 1'b0;
            trig_high  = 1'b0;
            gate       = 1'b0;
            elapsed    = 0;
            light_left = 0;
            fail_count = 0;
            checked    = 0;
            level_q.delete();
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (level_q.size() == 0)
                begin
                    $error("unexpected result word 0x%06h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_w = level_q.pop_front();
                    checked++;
                    if (m_tdata[15:0] !== exp_w.env_level)
                    begin
                        $error("env_level: expected %0d, got %0d",
                               exp_w.env_level, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[16] !== exp_w.trig_light)
                    begin
                        $error("trig_light: expected %0d, got %0d",
                               exp_w.trig_light, m_tdata[16]);
                        fail_count++;
                    end
                    if (m_tdata[17] !== exp_w.env_active)
                    begin
                        $error("env_active: expected %0d, got %0d",
                               exp_w.env_active, m_tdata[17]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                level_q.push_back(envelope_step(s_tdata[15:0], s_tdata[31:16]));
            if (wr_en)
            begin
                case (wr_index)
                    REG_SAMPLE_PERIOD: cfg_period = wr_data[SP_W-1:0];
                    REG_DECAY_TIME:    cfg_decay  = wr_data[DT_W-1:0];
                    REG_SHAPE:         cfg_shape  = wr_data[SHAPE_W-1:0];
                    REG_SHAPE_ROOT:    cfg_root   = wr_data[ROOT_W-1:0];
                    REG_CV_AMOUNT:     cfg_amount = wr_data[AMT_W-1:0];
                    REG_CV_ENABLE:     cfg_cv_en  = wr_data[0];
                    default: ;
                endcase
            end
            pending = level_q.size();
        end
    end
endmodule

// ===== verif/tb_triggered_shaped_decay_envelope_unit.sv =====
// Testbench top for the envelope unit: stimulus, idling, configuration phases and verdict
module tb_triggered_shaped_decay_envelope_unit;
    import tsde_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_TW-1:0] m_tdata;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_index;
    logic [CFG_W-1:0]  wr_data;

    int fail_count;
    int pending;
    int checked;
    int send_pct;
    int recv_pct;
    int hold_cycles;
    int sent;
    int cycles;

    triggered_shaped_decay_envelope_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    tsde_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL triggered_shaped_decay_envelope_unit");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_pct);
        end
    end

    task automatic send_word(logic [15:0] trig, logic [15:0] cv);
        while ($urandom_range(99) < send_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cv, trig};
        sent++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_config(int sp, int dt, int sh, int rt, int amt, int en);
        cfg_write(REG_SAMPLE_PERIOD, CFG_W'(sp));
        cfg_write(REG_DECAY_TIME, CFG_W'(dt));
        cfg_write(REG_SHAPE, CFG_W'(sh));
        cfg_write(REG_SHAPE_ROOT, CFG_W'(rt));
        cfg_write(REG_CV_AMOUNT, CFG_W'(amt));
        cfg_write(REG_CV_ENABLE, CFG_W'(en));
        wr_en <= 1'b0;
    endtask

    initial
    begin
        int n;
        int hi_len;
        int lo_len;
        logic [15:0] trig;
        logic [15:0] cv;
        bit held;
        bit drained;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        hold_cycles = 0;
        send_pct    = 9;
        recv_pct    = 45;
        sent        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults straight out of reset
        send_word(16'sd6554, 16'sd0);
        send_word(16'sd0, 16'sd0);
        wait_idle();

        // masked and ignored writes, then short decay with full CV
        cfg_write(REG_SHAPE, '1);
        cfg_write(3'd6, '1);
        cfg_write(3'd7, 26'h155_5555);
        load_config(16777, 167772, 64881, 65536, 65536, 1);
        send_word(16'sd6553, 16'h8000);
        send_word(16'sd6554, 16'h7FFF);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'sd328, 16'h7FFF);
        send_word(16'sd327, 16'h0000);
        send_word(16'h8000, 16'hFFFF);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'sd327, 16'h8000);
        for (int i = 0; i < 12; i++)
            send_word(16'h0000, 16'h8000);
        send_word(16'h7FFF, 16'h7FFF);
        for (int i = 0; i < 4; i++)
            send_word(16'h8000, 16'h0000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: load_config(16777, 167772, 0, 0, 0, 0);
                1: load_config(4000, 300000, 32768, 53222, 65536, 1);
                2: load_config(0, 167772, 20000, 40000, 1000, 1);
                5: load_config(1, 33554432, 64881, 65536, 65536, 1);
                7: load_config(16777, 33554432, 64881, 65536, 0, 0);
                default: load_config($urandom_range(2000, 16777),
                                     $urandom_range(167772, 2000000),
                                     $urandom_range(0, 64881), $urandom_range(0, 65536),
                                     $urandom_range(0, 65536), $urandom_range(0, 1));
            endcase
            if (ph < 3)
            begin
                send_pct = 9;
                recv_pct = 45;
            end
            else if (ph < 6)
            begin
                send_pct = 45;
                recv_pct = 9;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end
            n = 0;
            held = 1'b0;
            drained = 1'b0;
            while (n < PHASE_ITEMS)
            begin
                if (ph == 1 && n >= 50 && !held)
                begin
                    hold_cycles = 400;
                    held = 1'b1;
                end
                if (ph == 4 && n >= 100 && !drained)
                begin
                    drained = 1'b1;
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0)
                        @(posedge clk);
                end
                if ($urandom_range(99) < 80)
                begin
                    hi_len = $urandom_range(1, 4);
                    lo_len = $urandom_range(1, 30);
                    for (int i = 0; i < hi_len + lo_len; i++)
                    begin
                        if (i < hi_len)
                            trig = 16'($urandom_range(6554, 32767));
                        else if ($urandom_range(1))
                            trig = 16'($urandom_range(0, 327));
                        else
                            trig = 16'(-$urandom_range(0, 32768));
                        cv = 16'($urandom);
                        send_word(trig, cv);
                        n++;
                    end
                end
                else
                begin
                    send_word(16'($urandom), 16'($urandom));
                    n++;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d sample words over %0d configuration phases, checked %0d results.",
                 sent, PHASES + 2, checked);
        $display("Covered trigger thresholds, retriggers, attack, shaped decay, CV clamps.");
        if (fail_count == 0)
            $display("PASS triggered_shaped_decay_envelope_unit");
        else
            $display("FAIL triggered_shaped_decay_envelope_unit");
        $finish;
    end
endmodule
